### design/hbd_pkg.sv
// ----------------------------------------------------------------------------
// HTTP body dechunker package
// Shared count width, codes, queue entry type and the count clamp helper.
// ----------------------------------------------------------------------------
package hbd_pkg;

  // Width of the byte counters (chunk size, remaining bytes, size room).
  localparam int unsigned COUNT_WIDTH = 32;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [63:0] COUNT_MAX64 = (COUNT_WIDTH >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                           : ((64'd1 << COUNT_WIDTH) - 64'd1);

  // Body modes held in the body_mode register.
  localparam logic [1:0] MODE_CHUNKED = 2'd0;
  localparam logic [1:0] MODE_FIXED   = 2'd1;
  localparam logic [1:0] MODE_STREAM  = 2'd2;
  localparam logic [1:0] MODE_NONE    = 2'd3;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_START = 2'd1,
    KIND_EOS   = 2'd2
  } item_kind_e;

  // One classified input transaction as it travels from front to back.
  typedef struct packed {
    item_kind_e             kind;
    logic [7:0]             data;
    logic                   hex_ok;
    logic [3:0]             hex_val;
    logic                   is_cr;
    logic                   is_lf;
    logic [1:0]             mode;
    logic [COUNT_WIDTH-1:0] len;
    logic                   len_over;
    logic                   len_zero;
  } queue_entry_t;

  // Register values above the count range saturate to the largest count.
  function automatic logic [COUNT_WIDTH-1:0] clamp_count(input logic [31:0] v);
    logic [63:0] w;
    w = 64'(v);
    if (w > COUNT_MAX64) w = COUNT_MAX64;
    return w[COUNT_WIDTH-1:0];
  endfunction

endpackage

### design/hbd_queue.sv
// ----------------------------------------------------------------------------
// HTTP body dechunker item queue
// Short register queue that decouples the classifier from the executor.
// ----------------------------------------------------------------------------
module hbd_queue import hbd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  queue_entry_t push_data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         empty_o,
  output queue_entry_t head_o
);

  localparam int unsigned PtrWidth = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntWidth = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrWidth-1:0] PtrLast = PtrWidth'(QUEUE_DEPTH - 1);
  localparam logic [CntWidth-1:0] CntFull = CntWidth'(QUEUE_DEPTH);

  queue_entry_t                entries_q [QUEUE_DEPTH];
  logic         [PtrWidth-1:0] wr_ptr_q, wr_ptr_d;
  logic         [PtrWidth-1:0] rd_ptr_q, rd_ptr_d;
  logic         [CntWidth-1:0] count_q, count_d;
  logic                        do_push, do_pop;

  assign full_o  = (count_q == CntFull);
  assign empty_o = (count_q == '0);
  assign head_o  = entries_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    if (do_pop)  rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    if (do_push && !do_pop)      count_d = count_q + 1'b1;
    else if (!do_push && do_pop) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) entries_q[wr_ptr_q] <= push_data_i;
  end

endmodule

### design/hbd_front.sv
// ----------------------------------------------------------------------------
// HTTP body dechunker front end
// Holds the configuration registers, accepts input transactions and
// classifies each byte and command before it is queued.
// ----------------------------------------------------------------------------
module hbd_front import hbd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             command_i,
  input  logic [7:0]             data_byte_i,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [1:0]             cfg_index_i,
  input  logic [31:0]            cfg_data_i,
  input  logic                   queue_full_i,
  output logic                   push_o,
  output queue_entry_t           entry_o,
  output logic [COUNT_WIDTH-1:0] limit_o
);

  localparam logic [1:0] CMD_BYTE  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_EOS   = 2'd2;

  localparam logic [1:0] CFG_BODY_MODE  = 2'd0;
  localparam logic [1:0] CFG_CONTENT_LEN = 2'd1;
  localparam logic [1:0] CFG_SIZE_LIMIT = 2'd2;

  localparam logic [31:0] LIMIT_RESET = 32'd1048576;

  localparam logic [7:0] CHAR_0  = 8'h30;
  localparam logic [7:0] CHAR_9  = 8'h39;
  localparam logic [7:0] CHAR_LA = 8'h61;
  localparam logic [7:0] CHAR_LF = 8'h66;
  localparam logic [7:0] CHAR_UA = 8'h41;
  localparam logic [7:0] CHAR_UF = 8'h46;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_NL = 8'h0A;
  localparam logic [7:0] HEX_TEN = 8'd10;

  logic [1:0]             body_mode_q;
  logic [31:0]            content_length_q;
  logic [31:0]            size_limit_q;
  logic [COUNT_WIDTH-1:0] len_clamped;
  logic                   accept;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = queue_full_i;
  assign accept      = in_valid_i & ~queue_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      body_mode_q      <= MODE_CHUNKED;
      content_length_q <= '0;
      size_limit_q     <= LIMIT_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_BODY_MODE:   body_mode_q      <= cfg_data_i[1:0];
        CFG_CONTENT_LEN: content_length_q <= cfg_data_i;
        CFG_SIZE_LIMIT:  size_limit_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign limit_o     = clamp_count(size_limit_q);
  assign len_clamped = clamp_count(content_length_q);

  always_comb begin
    entry_o          = '0;
    entry_o.kind     = KIND_BYTE;
    entry_o.data     = data_byte_i;
    entry_o.is_cr    = (data_byte_i == CHAR_CR);
    entry_o.is_lf    = (data_byte_i == CHAR_NL);
    entry_o.mode     = body_mode_q;
    entry_o.len      = len_clamped;
    entry_o.len_over = (len_clamped > limit_o);
    entry_o.len_zero = (len_clamped == '0);
    priority if (data_byte_i >= CHAR_0 && data_byte_i <= CHAR_9) begin
      entry_o.hex_ok  = 1'b1;
      entry_o.hex_val = 4'(data_byte_i - CHAR_0);
    end else if (data_byte_i >= CHAR_LA && data_byte_i <= CHAR_LF) begin
      entry_o.hex_ok  = 1'b1;
      entry_o.hex_val = 4'(data_byte_i - CHAR_LA + HEX_TEN);
    end else if (data_byte_i >= CHAR_UA && data_byte_i <= CHAR_UF) begin
      entry_o.hex_ok  = 1'b1;
      entry_o.hex_val = 4'(data_byte_i - CHAR_UA + HEX_TEN);
    end else begin
      entry_o.hex_ok  = 1'b0;
    end

    push_o = 1'b0;
    unique case (command_i)
      CMD_BYTE: begin
        entry_o.kind = KIND_BYTE;
        push_o       = accept;
      end
      CMD_START: begin
        entry_o.kind = KIND_START;
        push_o       = accept;
      end
      CMD_EOS: begin
        entry_o.kind = KIND_EOS;
        push_o       = accept;
      end
      // The unused command is consumed and dropped here.
      default: push_o = 1'b0;
    endcase
  end

endmodule

### design/hbd_back.sv
// ----------------------------------------------------------------------------
// HTTP body dechunker back end
// Executes queued transactions against the framing state and holds the
// result in an output register.
// ----------------------------------------------------------------------------
module hbd_back import hbd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   queue_empty_i,
  input  queue_entry_t           head_i,
  output logic                   pop_o,
  input  logic [COUNT_WIDTH-1:0] limit_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [7:0]             payload_byte_o,
  output logic                   has_byte_o,
  output logic                   last_o,
  output logic [1:0]             status_o
);

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_FIXED    = 3'd1;
  localparam logic [2:0] PH_STREAM   = 3'd2;
  localparam logic [2:0] PH_CSIZE    = 3'd3;
  localparam logic [2:0] PH_CSIZE_LF = 3'd4;
  localparam logic [2:0] PH_CDATA    = 3'd5;
  localparam logic [2:0] PH_CDATA_CR = 3'd6;
  localparam logic [2:0] PH_CDATA_LF = 3'd7;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_TOO_BIG = 2'd2;

  localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);

  logic [2:0]             phase_q, phase_d;
  logic [COUNT_WIDTH-1:0] remain_q, remain_d;
  logic [COUNT_WIDTH-1:0] acc_q, acc_d;
  // Body bytes passed so far in stream and chunked bodies.
  logic [COUNT_WIDTH-1:0] total_q, total_d;
  logic                   digit_q, digit_d;
  logic                   final_q, final_d;

  logic                   out_valid_q;
  logic [7:0]             out_byte_q;
  logic                   out_has_q, out_last_q;
  logic [1:0]             out_status_q;

  logic                   out_free, go;
  logic                   res_valid, res_has, res_last;
  logic [7:0]             res_byte;
  logic [1:0]             res_status;
  logic [COUNT_WIDTH+3:0] acc_next;
  logic [COUNT_WIDTH-1:0] room;

  assign out_free = ~out_valid_q | ~out_stall_i;
  assign go       = out_free & ~queue_empty_i;
  assign pop_o    = go;
  assign acc_next = {acc_q, head_i.hex_val};
  assign room     = (limit_i > total_q) ? limit_i - total_q : '0;

  always_comb begin
    phase_d    = phase_q;
    remain_d   = remain_q;
    acc_d      = acc_q;
    total_d    = total_q;
    digit_d    = digit_q;
    final_d    = final_q;
    res_valid  = 1'b0;
    res_has    = 1'b0;
    res_last   = 1'b0;
    res_byte   = '0;
    res_status = STATUS_OK;

    if (go) begin
      unique case (head_i.kind)
        KIND_START: begin
          remain_d = '0;
          acc_d    = '0;
          total_d  = '0;
          digit_d  = 1'b0;
          final_d  = 1'b0;
          phase_d  = PH_IDLE;
          unique case (head_i.mode)
            MODE_CHUNKED: phase_d = PH_CSIZE;
            MODE_FIXED: begin
              priority if (head_i.len_over) begin
                res_valid  = 1'b1;
                res_last   = 1'b1;
                res_status = STATUS_TOO_BIG;
              end else if (head_i.len_zero) begin
                res_valid = 1'b1;
                res_last  = 1'b1;
              end else begin
                remain_d = head_i.len;
                phase_d  = PH_FIXED;
              end
            end
            MODE_STREAM: phase_d = PH_STREAM;
            MODE_NONE: begin
              res_valid = 1'b1;
              res_last  = 1'b1;
            end
            default: ;
          endcase
        end

        KIND_EOS: begin
          if (phase_q != PH_IDLE) begin
            res_valid = 1'b1;
            res_last  = 1'b1;
            if (phase_q != PH_STREAM) res_status = STATUS_INVALID;
            phase_d = PH_IDLE;
          end
        end

        KIND_BYTE: begin
          unique case (phase_q)
            PH_IDLE: ;
            PH_FIXED: begin
              remain_d  = remain_q - COUNT_ONE;
              res_valid = 1'b1;
              res_has   = 1'b1;
              res_byte  = head_i.data;
              if (remain_q == COUNT_ONE) begin
                res_last = 1'b1;
                phase_d  = PH_IDLE;
              end
            end
            PH_STREAM: begin
              res_valid = 1'b1;
              if (total_q >= limit_i) begin
                res_last   = 1'b1;
                res_status = STATUS_TOO_BIG;
                phase_d    = PH_IDLE;
              end else begin
                total_d  = total_q + COUNT_ONE;
                res_has  = 1'b1;
                res_byte = head_i.data;
              end
            end
            PH_CSIZE: begin
              if (head_i.hex_ok) begin
                // The new size must still fit in the room under the limit.
                if (acc_next > {4'b0000, room}) begin
                  res_valid  = 1'b1;
                  res_last   = 1'b1;
                  res_status = STATUS_TOO_BIG;
                  phase_d    = PH_IDLE;
                end else begin
                  acc_d   = acc_next[COUNT_WIDTH-1:0];
                  digit_d = 1'b1;
                end
              end else if (head_i.is_cr && digit_q) begin
                phase_d = PH_CSIZE_LF;
              end else begin
                res_valid  = 1'b1;
                res_last   = 1'b1;
                res_status = STATUS_INVALID;
                phase_d    = PH_IDLE;
              end
            end
            PH_CSIZE_LF: begin
              if (head_i.is_lf) begin
                remain_d = acc_q;
                acc_d    = '0;
                digit_d  = 1'b0;
                final_d  = (acc_q == '0);
                phase_d  = (acc_q == '0) ? PH_CDATA_CR : PH_CDATA;
              end else begin
                res_valid  = 1'b1;
                res_last   = 1'b1;
                res_status = STATUS_INVALID;
                phase_d    = PH_IDLE;
              end
            end
            PH_CDATA: begin
              remain_d  = remain_q - COUNT_ONE;
              total_d   = total_q + COUNT_ONE;
              res_valid = 1'b1;
              res_has   = 1'b1;
              res_byte  = head_i.data;
              if (remain_q == COUNT_ONE) phase_d = PH_CDATA_CR;
            end
            PH_CDATA_CR: begin
              if (head_i.is_cr) begin
                phase_d = PH_CDATA_LF;
              end else begin
                res_valid  = 1'b1;
                res_last   = 1'b1;
                res_status = STATUS_INVALID;
                phase_d    = PH_IDLE;
              end
            end
            PH_CDATA_LF: begin
              if (!head_i.is_lf) begin
                res_valid  = 1'b1;
                res_last   = 1'b1;
                res_status = STATUS_INVALID;
                phase_d    = PH_IDLE;
              end else if (final_q) begin
                res_valid = 1'b1;
                res_last  = 1'b1;
                phase_d   = PH_IDLE;
              end else begin
                phase_d = PH_CSIZE;
              end
            end
          endcase
        end

        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      remain_q    <= '0;
      acc_q       <= '0;
      total_q     <= '0;
      digit_q     <= 1'b0;
      final_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      remain_q <= remain_d;
      acc_q    <= acc_d;
      total_q  <= total_d;
      digit_q  <= digit_d;
      final_q  <= final_d;
      if (out_free) out_valid_q <= go & res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && res_valid) begin
      out_byte_q   <= res_byte;
      out_has_q    <= res_has;
      out_last_q   <= res_last;
      out_status_q <= res_status;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign payload_byte_o = out_byte_q;
  assign has_byte_o     = out_has_q;
  assign last_o         = out_last_q;
  assign status_o       = out_status_q;

endmodule

### design/http_body_dechunker_unit.sv
// ----------------------------------------------------------------------------
// HTTP body dechunker
// Path: an input transaction is written into a queue entry, then executed by
// the back end, which holds any result it gives in the output register.
// Throughput: one transaction per cycle while the output is not stalled. A
// result held in the output register stops the back end; the two-entry queue
// then fills and stalls the input.
// Reset: configuration returns to its reset values, the body is idle and the
// queue and output register are empty.
// ----------------------------------------------------------------------------
module http_body_dechunker_unit import hbd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  payload_byte_o,
  output logic        has_byte_o,
  output logic        last_o,
  output logic [1:0]  status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic                   push, pop, full, empty;
  queue_entry_t           entry, head;
  logic [COUNT_WIDTH-1:0] limit;

  hbd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .data_byte_i  (data_byte_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .queue_full_i (full),
    .push_o       (push),
    .entry_o      (entry),
    .limit_o      (limit)
  );

  hbd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (entry),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  hbd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .queue_empty_i  (empty),
    .head_i         (head),
    .pop_o          (pop),
    .limit_i        (limit),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .payload_byte_o (payload_byte_o),
    .has_byte_o     (has_byte_o),
    .last_o         (last_o),
    .status_o       (status_o)
  );

endmodule

### verif/hbd_tb_pkg.sv
// ----------------------------------------------------------------------------
// HTTP body dechunker verification package
// Register indexes, command and status codes and ASCII framing characters
// shared by the checker and the testbench top.
// ----------------------------------------------------------------------------
package hbd_tb_pkg;

  localparam logic [1:0] REG_BODY_MODE      = 2'd0;
  localparam logic [1:0] REG_CONTENT_LENGTH = 2'd1;
  localparam logic [1:0] REG_SIZE_LIMIT     = 2'd2;

  // Command value that the block ignores.
  localparam logic [1:0] CMD_RESERVED = 2'd3;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_FRAME = 2'd1;
  localparam logic [1:0] STATUS_TOO_LARGE = 2'd2;

  localparam logic [7:0] ASCII_CR = 8'h0D;
  localparam logic [7:0] ASCII_LF = 8'h0A;

  localparam logic [31:0] LIMIT_AT_RESET = 32'd1048576;

endpackage

### verif/http_body_dechunker_checker.sv
// ----------------------------------------------------------------------------
// HTTP body dechunker checker
// Watches the input, output and register channels, keeps its own model of
// the body framing state, and compares every output transaction field by
// field with the oldest predicted result.
// ----------------------------------------------------------------------------
module http_body_dechunker_checker import hbd_pkg::*; import hbd_tb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  command_i,
  input  logic [7:0]  data_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [7:0]  payload_byte_i,
  input  logic        has_byte_i,
  input  logic        last_i,
  input  logic [1:0]  status_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int          fail_count_o,
  output int          outstanding_o,
  output int          bytes_checked_o,
  output int          bodies_closed_o,
  output int          bodies_failed_o
);

  typedef enum logic [2:0] {
    FR_IDLE,
    FR_FIXED,
    FR_STREAM,
    FR_SIZE,
    FR_SIZE_LF,
    FR_DATA,
    FR_DATA_CR,
    FR_DATA_LF
  } frame_phase_e;

  typedef struct packed {
    logic [7:0] payload;
    logic       has_byte;
    logic       last;
    logic [1:0] status;
  } body_result_t;

  logic [1:0]   mode_cfg;
  logic [31:0]  length_cfg;
  logic [31:0]  limit_cfg;

  frame_phase_e phase_q;
  logic [63:0]  left_in_chunk;
  logic [63:0]  size_acc;
  logic [63:0]  body_total;
  logic         saw_digit;
  logic         zero_chunk;

  body_result_t awaited_results[$];

  function automatic body_result_t make_result(input logic [7:0] payload, input logic has,
                                               input logic last, input logic [1:0] status);
    body_result_t r;
    r.payload  = payload;
    r.has_byte = has;
    r.last     = last;
    r.status   = status;
    return r;
  endfunction

  function automatic bit close_body(input logic [1:0] status, output body_result_t r);
    phase_q = FR_IDLE;
    r = make_result(8'h00, 1'b0, 1'b1, status);
    return 1'b1;
  endfunction

  // Advances the framing state by one input transaction. Returns 1 when the
  // transaction produces a result, which is placed in r.
  function automatic bit dechunk_step(input logic [1:0] cmd, input logic [7:0] b,
                                      output body_result_t r);
    logic [63:0] limit;
    logic [63:0] len;
    logic [63:0] room;
    logic [63:0] digit;
    logic        is_hex;
    limit = (64'(limit_cfg) > COUNT_MAX64) ? COUNT_MAX64 : 64'(limit_cfg);
    len   = (64'(length_cfg) > COUNT_MAX64) ? COUNT_MAX64 : 64'(length_cfg);
    r = '0;
    case (cmd)
      KIND_START: begin
        left_in_chunk = '0;
        size_acc      = '0;
        body_total    = '0;
        saw_digit     = 1'b0;
        zero_chunk    = 1'b0;
        phase_q       = FR_IDLE;
        case (mode_cfg)
          MODE_CHUNKED: begin
            phase_q = FR_SIZE;
            return 1'b0;
          end
          MODE_FIXED: begin
            if (len > limit) return close_body(STATUS_TOO_LARGE, r);
            if (len == 0) return close_body(STATUS_OK, r);
            left_in_chunk = len;
            phase_q = FR_FIXED;
            return 1'b0;
          end
          MODE_STREAM: begin
            phase_q = FR_STREAM;
            return 1'b0;
          end
          default: return close_body(STATUS_OK, r);
        endcase
      end
      KIND_EOS: begin
        if (phase_q == FR_IDLE) return 1'b0;
        if (phase_q == FR_STREAM) return close_body(STATUS_OK, r);
        return close_body(STATUS_BAD_FRAME, r);
      end
      KIND_BYTE: begin
        case (phase_q)
          FR_FIXED: begin
            left_in_chunk = (left_in_chunk - 64'd1) & COUNT_MAX64;
            body_total    = (body_total + 64'd1) & COUNT_MAX64;
            if (left_in_chunk == 0) begin
              phase_q = FR_IDLE;
              r = make_result(b, 1'b1, 1'b1, STATUS_OK);
            end else begin
              r = make_result(b, 1'b1, 1'b0, STATUS_OK);
            end
            return 1'b1;
          end
          FR_STREAM: begin
            if (body_total >= limit) return close_body(STATUS_TOO_LARGE, r);
            body_total = body_total + 64'd1;
            r = make_result(b, 1'b1, 1'b0, STATUS_OK);
            return 1'b1;
          end
          FR_SIZE: begin
            room   = (limit > body_total) ? limit - body_total : 64'd0;
            is_hex = 1'b1;
            digit  = '0;
            if (b >= "0" && b <= "9") digit = 64'(b - "0");
            else if (b >= "a" && b <= "f") digit = 64'(b - "a" + 8'd10);
            else if (b >= "A" && b <= "F") digit = 64'(b - "A" + 8'd10);
            else is_hex = 1'b0;
            if (is_hex) begin
              // The digit is refused as soon as the size could not fit in
              // what is left under the limit.
              if (digit > room || size_acc > (room - digit) / 64'd16)
                return close_body(STATUS_TOO_LARGE, r);
              size_acc  = size_acc * 64'd16 + digit;
              saw_digit = 1'b1;
              return 1'b0;
            end
            if (b == ASCII_CR && saw_digit) begin
              phase_q = FR_SIZE_LF;
              return 1'b0;
            end
            return close_body(STATUS_BAD_FRAME, r);
          end
          FR_SIZE_LF: begin
            if (b != ASCII_LF) return close_body(STATUS_BAD_FRAME, r);
            left_in_chunk = size_acc;
            size_acc      = '0;
            saw_digit     = 1'b0;
            zero_chunk    = (left_in_chunk == 0);
            phase_q       = zero_chunk ? FR_DATA_CR : FR_DATA;
            return 1'b0;
          end
          FR_DATA: begin
            left_in_chunk = (left_in_chunk - 64'd1) & COUNT_MAX64;
            body_total    = (body_total + 64'd1) & COUNT_MAX64;
            if (left_in_chunk == 0) phase_q = FR_DATA_CR;
            r = make_result(b, 1'b1, 1'b0, STATUS_OK);
            return 1'b1;
          end
          FR_DATA_CR: begin
            if (b != ASCII_CR) return close_body(STATUS_BAD_FRAME, r);
            phase_q = FR_DATA_LF;
            return 1'b0;
          end
          FR_DATA_LF: begin
            if (b != ASCII_LF) return close_body(STATUS_BAD_FRAME, r);
            if (zero_chunk) return close_body(STATUS_OK, r);
            phase_q = FR_SIZE;
            return 1'b0;
          end
          default: return 1'b0;
        endcase
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] seen,
                                 input logic [31:0] wanted);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, seen, wanted);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    body_result_t want;
    body_result_t got;
    if (!rst_ni) begin
      mode_cfg        = MODE_CHUNKED;
      length_cfg      = '0;
      limit_cfg       = LIMIT_AT_RESET;
      phase_q         = FR_IDLE;
      left_in_chunk   = '0;
      size_acc        = '0;
      body_total      = '0;
      saw_digit       = 1'b0;
      zero_chunk      = 1'b0;
      awaited_results.delete();
      fail_count_o    = 0;
      bytes_checked_o = 0;
      bodies_closed_o = 0;
      bodies_failed_o = 0;
      outstanding_o  <= 0;
    end else begin
      // Outputs come first: a result can never belong to an input transaction
      // taken at the same edge.
      if (out_valid_i && !out_stall_i) begin
        got = make_result(payload_byte_i, has_byte_i, last_i, status_i);
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result", 32'(got), 32'd0);
        end else begin
          want = awaited_results.pop_front();
          if (got.payload != want.payload)
            report_mismatch("payload_byte", 32'(got.payload), 32'(want.payload));
          if (got.has_byte != want.has_byte)
            report_mismatch("has_byte", 32'(got.has_byte), 32'(want.has_byte));
          if (got.last != want.last)
            report_mismatch("last", 32'(got.last), 32'(want.last));
          if (got.status != want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
          if (want.has_byte) bytes_checked_o++;
          if (want.last) bodies_closed_o++;
          if (want.last && want.status != STATUS_OK) bodies_failed_o++;
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_BODY_MODE:      mode_cfg   = cfg_data_i[1:0];
          REG_CONTENT_LENGTH: length_cfg = cfg_data_i;
          REG_SIZE_LIMIT:     limit_cfg  = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (dechunk_step(command_i, data_byte_i, want)) awaited_results.push_back(want);
      end
      outstanding_o <= awaited_results.size();
    end
  end

endmodule

### verif/http_body_dechunker_unit_tb.sv
// ----------------------------------------------------------------------------
// HTTP body dechunker testbench
// Drives framed and broken bodies in every mode through the dechunker under
// random idling on both channels, with register settings changed between
// phases; a checker beside the block predicts and compares each result.
// ----------------------------------------------------------------------------
module http_body_dechunker_unit_tb;
  import hbd_pkg::*;
  import hbd_tb_pkg::*;

  localparam int RANDOM_ITEMS    = 750;
  localparam int SETTLE_CYCLES   = 6;
  localparam int HOLD_CYCLES     = 160;
  localparam int WATCHDOG_LIMIT  = 4000;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data;
  } stim_item_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [1:0]  command_i   = KIND_BYTE;
  logic [7:0]  data_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  payload_byte_o;
  logic        has_byte_o;
  logic        last_o;
  logic [1:0]  status_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = REG_BODY_MODE;
  logic [31:0] cfg_data_i  = 32'd0;

  int fail_count;
  int results_due;
  int bytes_checked;
  int bodies_closed;
  int bodies_failed;

  stim_item_t  body_q[$];
  logic [1:0]  cur_mode;
  logic [31:0] cur_length;
  int          items_sent     = 0;
  int          settings_count = 0;
  int          holds_done     = 0;
  int          idle_run       = 0;
  bit          sender_calm    = 1'b0;
  bit          hold_off_now   = 1'b0;

  http_body_dechunker_unit DUT (.*);

  http_body_dechunker_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .command_i      (command_i),
    .data_byte_i    (data_byte_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .payload_byte_i (payload_byte_o),
    .has_byte_i     (has_byte_o),
    .last_i         (last_o),
    .status_i       (status_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .fail_count_o   (fail_count),
    .outstanding_o  (results_due),
    .bytes_checked_o(bytes_checked),
    .bodies_closed_o(bodies_closed),
    .bodies_failed_o(bodies_failed)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pick_length();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom();
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  function automatic logic [31:0] pick_limit();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1, 2: return $urandom_range(1, 30);
      3: return 32'hFFFF_FFFF;
      4: return $urandom();
      5: return LIMIT_AT_RESET;
      default: return $urandom_range(31, 2000);
    endcase
  endfunction

  function automatic logic [1:0] pick_mode();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return MODE_CHUNKED;
    if (r < 7) return MODE_FIXED;
    if (r < 9) return MODE_STREAM;
    return MODE_NONE;
  endfunction

  function automatic void push_item(input logic [1:0] cmd, input logic [7:0] data);
    stim_item_t it;
    it.cmd  = cmd;
    it.data = data;
    body_q.push_back(it);
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_item(KIND_BYTE, s[i]);
  endfunction

  function automatic void push_crlf();
    push_item(KIND_BYTE, ASCII_CR);
    push_item(KIND_BYTE, ASCII_LF);
  endfunction

  function automatic void push_random_bytes(input int n);
    repeat (n) push_item(KIND_BYTE, 8'($urandom_range(0, 255)));
  endfunction

  function automatic void cut_body_to(input int n);
    while (body_q.size() > n) void'(body_q.pop_back());
  endfunction

  function automatic logic [7:0] pick_stray_char();
    case ($urandom_range(0, 5))
      0: return ASCII_CR;
      1: return ASCII_LF;
      2: return ";";
      3: return " ";
      4: return "g";
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void build_chunked();
    int    chunks;
    int    sz;
    int    cut;
    string hex;
    push_item(KIND_START, 8'($urandom_range(0, 255)));
    chunks = $urandom_range(1, 3);
    repeat (chunks) begin
      sz  = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(9, 40);
      hex = $sformatf("%0h", sz);
      if ($urandom_range(0, 1) == 1) hex = hex.toupper();
      if ($urandom_range(0, 5) == 0) hex = {"0", hex};
      push_text(hex);
      push_crlf();
      push_random_bytes(sz);
      push_crlf();
    end
    push_text("0");
    push_crlf();
    push_crlf();
    if ($urandom_range(0, 9) < 3) begin
      cut = $urandom_range(1, body_q.size() - 1);
      case ($urandom_range(0, 6))
        0: body_q[cut] = '{KIND_BYTE, pick_stray_char()};
        1: begin
          cut_body_to(cut);
          push_item(KIND_EOS, 8'($urandom_range(0, 255)));
        end
        // The next body's start drops this one.
        2: cut_body_to(cut);
        3: begin
          // A trailer field in place of the closing empty line.
          cut_body_to(body_q.size() - 2);
          push_text("X: 1");
          push_crlf();
          push_crlf();
        end
        4: begin
          cut_body_to(1);
          push_crlf();
        end
        // A chunk extension right after the first size digit.
        5: body_q.insert(2, '{KIND_BYTE, ";"});
        default: begin
          cut_body_to(1);
          push_text(($urandom_range(0, 1) == 1) ? "100000000" : $sformatf("%0h", $urandom()));
          push_crlf();
          push_random_bytes($urandom_range(0, 6));
          push_item(KIND_EOS, 8'h00);
        end
      endcase
    end
  endfunction

  function automatic void build_fixed();
    int n;
    push_item(KIND_START, 8'h00);
    n = (cur_length <= 40) ? int'(cur_length) : $urandom_range(0, 30);
    case ($urandom_range(0, 9))
      0, 1: begin
        push_random_bytes($urandom_range(0, n));
        push_item(KIND_EOS, 8'h00);
      end
      // When the length is at most 40, bytes past the end of the body arrive while idle.
      2: push_random_bytes(n + 2);
      default: push_random_bytes(n);
    endcase
    if (cur_length > 40) push_item(KIND_EOS, 8'h00);
  endfunction

  function automatic void build_body();
    case (cur_mode)
      MODE_CHUNKED: build_chunked();
      MODE_FIXED:   build_fixed();
      MODE_STREAM: begin
        push_item(KIND_START, 8'h00);
        push_random_bytes($urandom_range(0, 20));
        if ($urandom_range(0, 6) != 0) push_item(KIND_EOS, 8'($urandom_range(0, 255)));
      end
      default: begin
        push_item(KIND_START, 8'h00);
        push_random_bytes($urandom_range(0, 2));
      end
    endcase
  endfunction

  task automatic send_item(input stim_item_t it);
    int gap;
    gap = sender_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    command_i   <= it.cmd;
    data_byte_i <= it.data;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_body();
    foreach (body_q[i]) send_item(body_q[i]);
    items_sent += body_q.size();
    body_q.delete();
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 4))
      send_item('{2'($urandom_range(0, 3)), 8'($urandom_range(0, 255))});
  endtask

  // Waits until every predicted result has come out and the block is quiet.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (results_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic configure(input logic [1:0] mode, input logic [31:0] length,
                           input logic [31:0] limit);
    write_reg(REG_BODY_MODE, {30'd0, mode});
    write_reg(REG_CONTENT_LENGTH, length);
    write_reg(REG_SIZE_LIMIT, limit);
    cfg_valid_i <= 1'b0;
    cur_mode   = mode;
    cur_length = length;
    settings_count++;
  endtask

  // Receiver: random stalls, calm stretches, and one long hold-off on request.
  initial begin
    @(posedge clk_i);
    forever begin
      if (hold_off_now) begin
        hold_off_now = 1'b0;
        holds_done++;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat (pick_gap() + 1) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat (($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 6))
          @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_run <= 0;
    end else begin
      idle_run <= idle_run + 1;
    end
    if (idle_run >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $realtime, idle_run);
      $display("http_body_dechunker_unit_tb failed");
      $finish;
    end
  end

  initial begin
    int directed_items;
    int phase_no;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: chunked body. Idle bytes, end of stream and the
    // reserved command are ignored, then one framed body with one byte.
    cur_mode = MODE_CHUNKED;
    push_item(KIND_BYTE, 8'hFF);
    push_item(KIND_EOS, 8'h00);
    push_item(CMD_RESERVED, 8'h00);
    push_item(KIND_START, 8'h00);
    push_text("1");
    push_crlf();
    push_item(KIND_BYTE, 8'hFF);
    push_crlf();
    push_text("0");
    push_crlf();
    push_crlf();
    send_body();

    drain();
    configure(MODE_NONE, 32'd0, LIMIT_AT_RESET);
    push_item(KIND_START, 8'h00);
    send_body();

    drain();
    configure(MODE_FIXED, 32'd0, 32'hFFFF_FFFF);
    push_item(KIND_START, 8'h00);
    send_body();

    // Fixed length beyond the limit is refused at the start.
    drain();
    configure(MODE_FIXED, 32'hFFFF_FFFF, 32'd0);
    push_item(KIND_START, 8'h00);
    send_body();

    drain();
    configure(MODE_FIXED, 32'd2, 32'd2);
    push_item(KIND_START, 8'h00);
    push_item(KIND_BYTE, 8'h00);
    push_item(KIND_BYTE, 8'hFF);
    send_body();

    drain();
    configure(MODE_STREAM, 32'd0, 32'd0);
    push_item(KIND_START, 8'h00);
    push_item(KIND_BYTE, 8'hA5);
    send_body();

    drain();
    configure(MODE_STREAM, 32'd0, 32'hFFFF_FFFF);
    push_item(KIND_START, 8'h00);
    push_item(KIND_BYTE, 8'h5A);
    push_item(KIND_EOS, 8'h00);
    send_body();

    // A chunk extension, then a body cut short by end of stream.
    drain();
    configure(MODE_CHUNKED, 32'd0, 32'hFFFF_FFFF);
    push_item(KIND_START, 8'h00);
    push_text("1;");
    push_item(KIND_START, 8'h00);
    push_text("2");
    push_crlf();
    push_text("x");
    push_item(KIND_EOS, 8'h00);
    send_body();
    directed_items = items_sent;

    phase_no = 0;
    while (items_sent - directed_items < RANDOM_ITEMS) begin
      drain();
      if (phase_no == 0) begin
        // A stream body under a long receiver hold-off fills the block.
        configure(MODE_STREAM, 32'd0, 32'hFFFF_FFFF);
        hold_off_now = 1'b1;
        wait (holds_done != 0);
        sender_calm = 1'b1;
        push_item(KIND_START, 8'h00);
        push_random_bytes(30);
        send_body();
      end else begin
        configure(pick_mode(), pick_length(), pick_limit());
      end
      repeat ($urandom_range(2, 6)) begin
        sender_calm = ($urandom_range(0, 4) == 0);
        build_body();
        send_body();
        if ($urandom_range(0, 9) == 0) send_noise();
      end
      phase_no++;
    end

    drain();
    $display("Sent %0d input transactions under %0d register settings, %0d receiver hold-offs.",
             items_sent, settings_count, holds_done);
    $display("Checked %0d body bytes and %0d body endings, %0d of them with an error status.",
             bytes_checked, bodies_closed, bodies_failed);
    if (fail_count == 0) begin
      $display("http_body_dechunker_unit_tb passed");
    end else begin
      $display("http_body_dechunker_unit_tb failed");
    end
    $finish;
  end

endmodule

### files.f
design/hbd_pkg.sv
design/hbd_queue.sv
design/hbd_front.sv
design/hbd_back.sv
design/http_body_dechunker_unit.sv
verif/hbd_tb_pkg.sv
verif/http_body_dechunker_checker.sv
verif/http_body_dechunker_unit_tb.sv
